### hdl/lobm_pkg.sv
// Shared types and constants of the order book matcher.
package lobm_pkg;
  localparam int unsigned BookDepth  = 16;
  localparam int unsigned IdxW       = $clog2(BookDepth);
  localparam int unsigned CntW       = $clog2(BookDepth + 1);
  localparam int unsigned MaxResults = 32;
  localparam int unsigned ResW       = $clog2(MaxResults + 1);

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StTrade    = 2'd2;
  localparam logic [1:0] StNoTrade  = 2'd3;

  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncMatch = 1'b1;
  localparam logic SideBuy   = 1'b0;
  localparam logic SideSell  = 1'b1;

  typedef struct packed {
    logic ins_bid;   // shift-insert the latched order into the bid chain
    logic ins_ask;   // shift-insert the latched order into the ask chain
    logic trade;     // reduce both heads by the lesser quantity, pop filled heads
  } lobm_cmd_t;

  typedef struct packed {
    logic        bid_full;
    logic        ask_full;
    logic        crossed;   // both sides nonempty and best bid >= best ask
    logic [15:0] match_qty;
    logic [15:0] ask_price;
  } lobm_stat_t;
endpackage

### hdl/lobm_datapath.sv
// Datapath of the order book matcher: the two sorted shift chains and the trade arithmetic.
module lobm_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lobm_pkg::lobm_cmd_t  cmd_i,
  input  logic [15:0]       price_i,
  input  logic [15:0]       qty_i,
  output lobm_pkg::lobm_stat_t stat_o
);
  import lobm_pkg::*;

  logic [15:0] bp_q [BookDepth];
  logic [15:0] bq_q [BookDepth];
  logic [15:0] ap_q [BookDepth];
  logic [15:0] aq_q [BookDepth];
  logic [CntW-1:0] bcnt_q, acnt_q;

  logic [15:0] m;
  logic        bid_fill, ask_fill;
  logic [BookDepth-1:0] bbeh, abeh;

  assign m        = (bq_q[0] < aq_q[0]) ? bq_q[0] : aq_q[0];
  assign bid_fill = (bq_q[0] == m);
  assign ask_fill = (aq_q[0] == m);

  always_comb begin
    for (int i = 0; i < BookDepth; i++) begin
      bbeh[i] = (CntW'(i) >= bcnt_q) || (bp_q[i] < price_i);
      abeh[i] = (CntW'(i) >= acnt_q) || (ap_q[i] > price_i);
    end
  end

  assign stat_o.bid_full  = (bcnt_q == CntW'(BookDepth));
  assign stat_o.ask_full  = (acnt_q == CntW'(BookDepth));
  assign stat_o.crossed   = (bcnt_q != '0) && (acnt_q != '0) && (bp_q[0] >= ap_q[0]);
  assign stat_o.match_qty = m;
  assign stat_o.ask_price = ap_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
      acnt_q <= '0;
    end else begin
      if (cmd_i.ins_bid) bcnt_q <= bcnt_q + 1'b1;
      else if (cmd_i.trade && bid_fill) bcnt_q <= bcnt_q - 1'b1;
      if (cmd_i.ins_ask) acnt_q <= acnt_q + 1'b1;
      else if (cmd_i.trade && ask_fill) acnt_q <= acnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < BookDepth; i++) begin
      if (cmd_i.ins_bid && bbeh[i]) begin
        if (i == 0 || !bbeh[(i == 0) ? 0 : i-1]) begin
          bp_q[i] <= price_i;
          bq_q[i] <= qty_i;
        end else begin
          bp_q[i] <= bp_q[(i == 0) ? 0 : i-1];
          bq_q[i] <= bq_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.trade) begin
        if (bid_fill) begin
          if (i < BookDepth-1) begin
            bp_q[i] <= bp_q[(i < BookDepth-1) ? i+1 : i];
            bq_q[i] <= bq_q[(i < BookDepth-1) ? i+1 : i];
          end
        end else if (i == 0) begin
          bq_q[0] <= bq_q[0] - m;
        end
      end
      if (cmd_i.ins_ask && abeh[i]) begin
        if (i == 0 || !abeh[(i == 0) ? 0 : i-1]) begin
          ap_q[i] <= price_i;
          aq_q[i] <= qty_i;
        end else begin
          ap_q[i] <= ap_q[(i == 0) ? 0 : i-1];
          aq_q[i] <= aq_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.trade) begin
        if (ask_fill) begin
          if (i < BookDepth-1) begin
            ap_q[i] <= ap_q[(i < BookDepth-1) ? i+1 : i];
            aq_q[i] <= aq_q[(i < BookDepth-1) ? i+1 : i];
          end
        end else if (i == 0) begin
          aq_q[0] <= aq_q[0] - m;
        end
      end
    end
  end
endmodule

### hdl/lobm_ctrl.sv
// Controller of the order book matcher: request sequencing and result register.
module lobm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic                 func_i,
  input  logic                 side_i,
  input  logic [15:0]          qty_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [1:0]           status_o,
  output logic [15:0]          tqty_o,
  output logic [15:0]          tprice_o,
  output logic                 last_o,
  input  lobm_pkg::lobm_stat_t stat_i,
  output lobm_pkg::lobm_cmd_t  cmd_o
);
  import lobm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_MATCH} state_e;
  state_e state_q;
  logic   side_q, qnz_q;
  logic [ResW-1:0] n_q;
  logic   ovalid_q;
  logic   free;

  assign free      = !ovalid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = ovalid_q;

  always_comb begin
    cmd_o = '0;
    if (state_q == S_ADD && free && qnz_q) begin
      cmd_o.ins_bid = (side_q == SideBuy) && !stat_i.bid_full;
      cmd_o.ins_ask = (side_q != SideBuy) && !stat_i.ask_full;
    end
    if (state_q == S_MATCH && free && stat_i.crossed && n_q < ResW'(MaxResults))
      cmd_o.trade = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      side_q   <= 1'b0;
      qnz_q    <= 1'b0;
      n_q      <= '0;
      status_o <= StAccepted;
      tqty_o   <= '0;
      tprice_o <= '0;
      last_o   <= 1'b0;
    end else begin
      if (ovalid_q && m_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            side_q  <= side_i;
            qnz_q   <= (qty_i != '0);
            n_q     <= '0;
            state_q <= (func_i == FuncAdd) ? S_ADD : S_MATCH;
          end
        end
        S_ADD: begin
          if (free) begin
            ovalid_q <= 1'b1;
            status_o <= ((side_q == SideBuy) ? stat_i.bid_full : stat_i.ask_full)
                        ? StFull : StAccepted;
            tqty_o   <= '0;
            tprice_o <= '0;
            last_o   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_MATCH: begin
          if (free) begin
            if (cmd_o.trade) begin
              // hold last low; the top level raises last once the book no longer crosses
              ovalid_q <= 1'b1;
              status_o <= StTrade;
              tqty_o   <= stat_i.match_qty;
              tprice_o <= stat_i.ask_price;
              last_o   <= 1'b0;
              n_q      <= n_q + 1'b1;
            end else begin
              if (n_q == '0) begin
                ovalid_q <= 1'b1;
                status_o <= StNoTrade;
                tqty_o   <= '0;
                tprice_o <= '0;
                last_o   <= 1'b1;
              end
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/limit_order_book_matcher_unit.sv
// Top level of the limit order book matcher.
// Single-instrument order book: bids sorted by descending price, asks by ascending price,
// equal prices in arrival order, each side a shift chain of BookDepth entries. An add request
// is latched, then shift-inserted, and returns one result. A match request is latched, then
// trades the heads (head compare and subtract) while the book crosses, then detects the end
// of the crossing (emitting the no-trade result when no trade happened); it returns one
// no-trade result, or one result per trade (at most MaxResults) with last on the final one
// unless the MaxResults limit ends the pass while the book still crosses. Output stalls hold
// the sequencer. No requests are taken while one is in progress.
module limit_order_book_matcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] quantity, [31:16] price
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] trade_quantity, [31:16] trade_price
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);
  import lobm_pkg::*;

  lobm_cmd_t   cmd;
  lobm_stat_t  stat;
  logic [15:0] price_q, qty_q, tq, tp;
  logic [1:0]  st;
  logic        last_w;
  logic        last_fix;

  // hold the order payload for the insert cycle
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      qty_q   <= s_axis_tdata[15:0];
      price_q <= s_axis_tdata[31:16];
    end
  end

  lobm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .func_i(s_axis_tuser[0]), .side_i(s_axis_tuser[1]), .qty_i(s_axis_tdata[15:0]),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .status_o(st), .tqty_o(tq), .tprice_o(tp), .last_o(last_w),
    .stat_i(stat), .cmd_o(cmd)
  );

  lobm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .price_i(price_q), .qty_i(qty_q), .stat_o(stat)
  );

  // the book already holds the post-trade state while a trade is shown: if it no longer
  // crosses, that trade ends the pass, so raise last
  assign last_fix = (st == StTrade) && !stat.crossed && !cmd.trade;

  assign m_axis_tdata = {tp, tq};
  assign m_axis_tuser = st;
  assign m_axis_tlast = last_w || last_fix;

`ifndef SYNTH
  a_no_dual_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ins_bid && cmd.ins_ask)) else $error("dual insert");
  a_trade_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && st == StTrade) |-> (tq != '0)) else $error("empty trade");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.trade) else $error("trade while idle");
`endif
endmodule
